// ===== src/rpe_pkg.sv =====
// Shared widths, register indexes and the arctangent table of the relative pose core.
package rpe_pkg;

   localparam int Q_W          = 16;   // quaternion component, Q1.14
   localparam int P_W          = 32;   // translation, Q16.16
   localparam int R_W          = 30;   // rotation element, Q24
   localparam int D_W          = 33;   // translation difference
   localparam int M_W          = 32;   // relative rotation element, Q20
   localparam int SQ_W         = 62;   // sum of squares
   localparam int ROOT_W       = 31;   // hypotenuse
   localparam int SQRT_STEPS   = 31;
   localparam int CIN_W        = 33;   // arctangent operands
   localparam int C_W          = 36;   // arctangent vector width
   localparam int ANG_W        = 30;   // angle, Q20 degrees
   localparam int CORDIC_STEPS = 27;
   localparam int CORDIC_DEPTH = CORDIC_STEPS + 1;
   localparam int DEG_W        = 17;   // rounded angle before clamping

   localparam logic signed [ANG_W-1:0] DEG90_Q20 = ANG_W'(90 * 1048576);
   localparam logic signed [DEG_W-1:0] ROLL_LIM  = DEG_W'(23040);
   localparam logic signed [DEG_W-1:0] PITCH_LIM = DEG_W'(11520);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_QX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_QY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_QZ = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_QW = 3'd6;

   function automatic logic signed [ANG_W-1:0] atan_q20(input int unsigned i);
      logic signed [ANG_W-1:0] a;
      unique case (i)
         0:  a = ANG_W'(47185920);
         1:  a = ANG_W'(27855475);
         2:  a = ANG_W'(14718068);
         3:  a = ANG_W'(7471121);
         4:  a = ANG_W'(3750058);
         5:  a = ANG_W'(1876857);
         6:  a = ANG_W'(938658);
         7:  a = ANG_W'(469357);
         8:  a = ANG_W'(234682);
         9:  a = ANG_W'(117342);
         10: a = ANG_W'(58671);
         11: a = ANG_W'(29335);
         12: a = ANG_W'(14668);
         13: a = ANG_W'(7334);
         14: a = ANG_W'(3667);
         15: a = ANG_W'(1833);
         16: a = ANG_W'(917);
         17: a = ANG_W'(458);
         18: a = ANG_W'(229);
         19: a = ANG_W'(115);
         20: a = ANG_W'(57);
         21: a = ANG_W'(29);
         22: a = ANG_W'(14);
         23: a = ANG_W'(7);
         24: a = ANG_W'(4);
         25: a = ANG_W'(2);
         26: a = ANG_W'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== src/rpe_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module rpe_isqrt (
   input  logic                        clock,
   input  logic                        pipe_en,
   input  logic [rpe_pkg::SQ_W-1:0]    val_in,
   output logic [rpe_pkg::ROOT_W-1:0]  root_out
);
   import rpe_pkg::*;

   localparam int REM_W = ROOT_W + 2;

   logic [REM_W-1:0]  rem_ff  [SQRT_STEPS];
   logic [ROOT_W-1:0] root_ff [SQRT_STEPS];
   logic [SQ_W-1:0]   val_ff  [SQRT_STEPS];
   logic [REM_W-1:0]  rem_in  [SQRT_STEPS];
   logic [ROOT_W-1:0] root_in [SQRT_STEPS];
   logic [SQ_W-1:0]   val_in_s[SQRT_STEPS];

   always_comb begin
      for (int s = 0; s < SQRT_STEPS; s++) begin
         logic [REM_W-1:0]  rp;
         logic [ROOT_W-1:0] qp;
         logic [SQ_W-1:0]   vp;
         logic [REM_W+1:0]  rt;
         logic [REM_W+1:0]  trial;
         rp = (s == 0) ? '0 : rem_ff[(s == 0) ? 0 : s - 1];
         qp = (s == 0) ? '0 : root_ff[(s == 0) ? 0 : s - 1];
         vp = (s == 0) ? val_in : val_ff[(s == 0) ? 0 : s - 1];
         rt = {rp, vp[SQ_W-1:SQ_W-2]};
         trial = {1'b0, qp, 2'b01};
         if (rt >= trial) begin
            rem_in[s]  = REM_W'(rt - trial);
            root_in[s] = {qp[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[s]  = REM_W'(rt);
            root_in[s] = {qp[ROOT_W-2:0], 1'b0};
         end
         val_in_s[s] = {vp[SQ_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int s = 0; s < SQRT_STEPS; s++) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            val_ff[s]  <= val_in_s[s];
         end
      end
   end

   assign root_out = root_ff[SQRT_STEPS-1];

endmodule

// ===== src/rpe_cordic.sv =====
// Pipelined vectoring arctangent: quarter-turn pre-rotation and fixed micro-rotations.
module rpe_cordic (
   input  logic                              clock,
   input  logic                              pipe_en,
   input  logic signed [rpe_pkg::CIN_W-1:0]  y_in,
   input  logic signed [rpe_pkg::CIN_W-1:0]  x_in,
   output logic signed [rpe_pkg::ANG_W-1:0]  ang_out,
   output logic                              zero_out
);
   import rpe_pkg::*;

   logic signed [C_W-1:0]   x_ff [CORDIC_DEPTH];
   logic signed [C_W-1:0]   y_ff [CORDIC_DEPTH];
   logic signed [ANG_W-1:0] a_ff [CORDIC_DEPTH];
   logic                    z_ff [CORDIC_DEPTH];
   logic signed [C_W-1:0]   x_in_s [CORDIC_DEPTH];
   logic signed [C_W-1:0]   y_in_s [CORDIC_DEPTH];
   logic signed [ANG_W-1:0] a_in   [CORDIC_DEPTH];

   always_comb begin
      logic signed [C_W-1:0] xe;
      logic signed [C_W-1:0] ye;
      xe = C_W'(x_in);
      ye = C_W'(y_in);
      // pre-rotation for the left half plane
      if (xe < 0) begin
         if (ye >= 0) begin
            x_in_s[0] = ye;
            y_in_s[0] = -xe;
            a_in[0]   = DEG90_Q20;
         end else begin
            x_in_s[0] = -ye;
            y_in_s[0] = xe;
            a_in[0]   = -DEG90_Q20;
         end
      end else begin
         x_in_s[0] = xe;
         y_in_s[0] = ye;
         a_in[0]   = '0;
      end
      for (int s = 0; s < CORDIC_STEPS; s++) begin
         logic signed [C_W-1:0] xs;
         logic signed [C_W-1:0] ys;
         xs = x_ff[s] >>> s;
         ys = y_ff[s] >>> s;
         if (y_ff[s] > 0) begin
            x_in_s[s+1] = x_ff[s] + ys;
            y_in_s[s+1] = y_ff[s] - xs;
            a_in[s+1]   = a_ff[s] + atan_q20(s);
         end else begin
            x_in_s[s+1] = x_ff[s] - ys;
            y_in_s[s+1] = y_ff[s] + xs;
            a_in[s+1]   = a_ff[s] - atan_q20(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int s = 0; s < CORDIC_DEPTH; s++) begin
            x_ff[s] <= x_in_s[s];
            y_ff[s] <= y_in_s[s];
            a_ff[s] <= a_in[s];
         end
         z_ff[0] <= (x_in == '0) && (y_in == '0);
         for (int s = 1; s < CORDIC_DEPTH; s++) begin
            z_ff[s] <= z_ff[s-1];
         end
      end
   end

   assign ang_out  = a_ff[CORDIC_DEPTH-1];
   assign zero_out = z_ff[CORDIC_DEPTH-1];

endmodule

// ===== src/relative_pose_euler_core.sv =====
// Relative rigid pose core: second pose in the reference frame as ZYX Euler angles.
//
// Takes one pose item per cycle while req_stall is low and returns one result
// item per pose through five arithmetic stages (rotation matrices, products, sums
// with rounding and translation saturation, squares, sum of squares), 31 square
// root stages for the pitch hypotenuse, 28 arctangent stages (pre-rotation plus
// 27 micro-rotations, three units side by side) and the output register. The
// whole pipeline advances together; it freezes only while a result item waits at
// the output and the receiver stalls, so req_stall is rsp_valid and rsp_stall.
// The user must write the reference pose through the csr port only while no item
// is in flight; the block does not enforce this. Writes to indexes above six are
// dropped. At gimbal lock roll and yaw read zero and rsp_gimbal_lock is set.
module relative_pose_euler_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rpe_pkg::P_W-1:0]      req_pos_x,
   input  logic signed [rpe_pkg::P_W-1:0]      req_pos_y,
   input  logic signed [rpe_pkg::P_W-1:0]      req_pos_z,
   input  logic signed [rpe_pkg::Q_W-1:0]      req_quat_x,
   input  logic signed [rpe_pkg::Q_W-1:0]      req_quat_y,
   input  logic signed [rpe_pkg::Q_W-1:0]      req_quat_z,
   input  logic signed [rpe_pkg::Q_W-1:0]      req_quat_w,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [15:0]                  rsp_roll_deg,
   output logic signed [14:0]                  rsp_pitch_deg,
   output logic signed [15:0]                  rsp_yaw_deg,
   output logic signed [rpe_pkg::P_W-1:0]      rsp_rel_x,
   output logic signed [rpe_pkg::P_W-1:0]      rsp_rel_y,
   output logic signed [rpe_pkg::P_W-1:0]      rsp_rel_z,
   output logic                                rsp_gimbal_lock,
   input  logic                                csr_we,
   input  logic [rpe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_wdata
);
   import rpe_pkg::*;

   localparam int NV = 5 + SQRT_STEPS + CORDIC_DEPTH;
   localparam int E_W = 36;
   localparam logic signed [E_W-1:0] ONE_Q28 = E_W'(268435456);
   localparam logic signed [E_W-1:0] HALF4   = E_W'(8);
   localparam logic signed [61:0]    HALF28  = 62'sd134217728;
   localparam logic signed [64:0]    HALF24  = 65'sd8388608;
   localparam logic signed [40:0]    S32_MAX = 41'sd2147483647;
   localparam logic signed [40:0]    S32_MIN = -41'sd2147483648;
   localparam logic signed [ANG_W-1:0] HALF13 = ANG_W'(4096);

   // rows and columns of the relative rotation elements used: m00 m10 m20 m21 m22
   localparam int MROW [5] = '{0, 1, 2, 2, 2};
   localparam int MCOL [5] = '{0, 0, 0, 1, 2};

   typedef struct packed {
      logic signed [M_W-1:0] m00;
      logic signed [M_W-1:0] m10;
      logic signed [M_W-1:0] m20;
      logic signed [M_W-1:0] m21;
      logic signed [M_W-1:0] m22;
      logic [2:0][P_W-1:0]   rel;
      logic                  lock;
   } side_type;

   typedef struct packed {
      logic [2:0][P_W-1:0] rel;
      logic                lock;
   } tail_type;

   // reference pose registers
   logic signed [P_W-1:0] ref_x_ff, ref_y_ff, ref_z_ff;
   logic signed [Q_W-1:0] ref_qx_ff, ref_qy_ff, ref_qz_ff, ref_qw_ff;

   logic pipe_en;
   logic v_ff [NV];

   logic signed [R_W-1:0] r1_c [9];
   logic signed [R_W-1:0] r2_c [9];
   logic signed [R_W-1:0] r1_ff [9];
   logic signed [R_W-1:0] s1_r2_ff [9];
   logic signed [D_W-1:0] s1_d_ff [3];

   logic signed [2*R_W-1:0]     s2_mp_ff [5][3];
   logic signed [R_W+D_W-1:0]   s2_tp_ff [3][3];

   side_type s3_side_in, s3_side_ff, s4_side_ff, s5_side_ff;
   logic [SQ_W-1:0] s4_sq00_ff, s4_sq10_ff, s5_sum_ff;
   side_type sd1_ff [SQRT_STEPS];
   tail_type sd2_ff [CORDIC_DEPTH];

   logic [ROOT_W-1:0] hyp;
   side_type          cs;
   logic signed [ANG_W-1:0] ang_p, ang_y, ang_r;
   logic                    zero_p, zero_y, zero_r;

   logic signed [DEG_W-1:0] roll_in, pitch_in, yaw_in;
   logic signed [15:0]      roll_ff, yaw_ff;
   logic signed [14:0]      pitch_ff;
   logic [2:0][P_W-1:0]     rel_ff;
   logic                    lock_ff;
   logic                    rsp_valid_ff;

   // advance everything unless a result item is held at the output
   assign pipe_en   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff  <= '0;
         ref_y_ff  <= '0;
         ref_z_ff  <= '0;
         ref_qx_ff <= '0;
         ref_qy_ff <= '0;
         ref_qz_ff <= '0;
         ref_qw_ff <= Q_W'(16384);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REF_X:  ref_x_ff  <= csr_wdata;
            CSR_REF_Y:  ref_y_ff  <= csr_wdata;
            CSR_REF_Z:  ref_z_ff  <= csr_wdata;
            CSR_REF_QX: ref_qx_ff <= csr_wdata[Q_W-1:0];
            CSR_REF_QY: ref_qy_ff <= csr_wdata[Q_W-1:0];
            CSR_REF_QZ: ref_qz_ff <= csr_wdata[Q_W-1:0];
            CSR_REF_QW: ref_qw_ff <= csr_wdata[Q_W-1:0];
            default: ;
         endcase
      end
   end

   // quaternion to rotation matrix, for the reference and for the incoming pose
   always_comb begin
      for (int q = 0; q < 2; q++) begin
         logic signed [Q_W-1:0] x, y, z, w;
         logic signed [E_W-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
         logic signed [E_W-1:0] e [9];
         if (q == 0) begin
            x = ref_qx_ff; y = ref_qy_ff; z = ref_qz_ff; w = ref_qw_ff;
         end else begin
            x = req_quat_x; y = req_quat_y; z = req_quat_z; w = req_quat_w;
         end
         xx = E_W'(x * x); yy = E_W'(y * y); zz = E_W'(z * z);
         xy = E_W'(x * y); xz = E_W'(x * z); yz = E_W'(y * z);
         xw = E_W'(x * w); yw = E_W'(y * w); zw = E_W'(z * w);
         e[0] = ONE_Q28 - ((yy + zz) <<< 1);
         e[1] = (xy - zw) <<< 1;
         e[2] = (xz + yw) <<< 1;
         e[3] = (xy + zw) <<< 1;
         e[4] = ONE_Q28 - ((xx + zz) <<< 1);
         e[5] = (yz - xw) <<< 1;
         e[6] = (xz - yw) <<< 1;
         e[7] = (yz + xw) <<< 1;
         e[8] = ONE_Q28 - ((xx + yy) <<< 1);
         for (int k = 0; k < 9; k++) begin
            logic signed [E_W-1:0] rr;
            rr = (e[k] + HALF4) >>> 4;
            if (q == 0) r1_c[k] = rr[R_W-1:0];
            else        r2_c[k] = rr[R_W-1:0];
         end
      end
   end

   // the user must keep the reference rotation static while items are in flight; the block does not enforce this
   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) r1_ff[k] <= r1_c[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NV; i++) v_ff[i] <= 1'b0;
      end else if (pipe_en) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < NV; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k < 9; k++) s1_r2_ff[k] <= r2_c[k];
         s1_d_ff[0] <= D_W'(req_pos_x) - D_W'(ref_x_ff);
         s1_d_ff[1] <= D_W'(req_pos_y) - D_W'(ref_y_ff);
         s1_d_ff[2] <= D_W'(req_pos_z) - D_W'(ref_z_ff);
      end
   end

   // products of R1^T against R2 and against the translation difference
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int n = 0; n < 5; n++) begin
            for (int k = 0; k < 3; k++) begin
               s2_mp_ff[n][k] <= r1_ff[3*k + MROW[n]] * s1_r2_ff[3*k + MCOL[n]];
            end
         end
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               s2_tp_ff[i][k] <= (R_W+D_W)'(r1_ff[3*k + i]) * (R_W+D_W)'(s1_d_ff[k]);
            end
         end
      end
   end

   // sum, round to Q20 and Q16.16, saturate the translation
   always_comb begin
      logic signed [M_W-1:0] m [5];
      for (int n = 0; n < 5; n++) begin
         logic signed [61:0] acc;
         logic signed [61:0] rr;
         acc = 62'(s2_mp_ff[n][0]) + 62'(s2_mp_ff[n][1]) + 62'(s2_mp_ff[n][2]);
         rr  = (acc + HALF28) >>> 28;
         m[n] = rr[M_W-1:0];
      end
      s3_side_in.m00 = m[0];
      s3_side_in.m10 = m[1];
      s3_side_in.m20 = m[2];
      s3_side_in.m21 = m[3];
      s3_side_in.m22 = m[4];
      for (int i = 0; i < 3; i++) begin
         logic signed [64:0] acc;
         logic signed [64:0] rr;
         logic signed [40:0] t;
         acc = 65'(s2_tp_ff[i][0]) + 65'(s2_tp_ff[i][1]) + 65'(s2_tp_ff[i][2]);
         rr  = (acc + HALF24) >>> 24;
         t   = rr[40:0];
         if (t > S32_MAX)      s3_side_in.rel[i] = S32_MAX[P_W-1:0];
         else if (t < S32_MIN) s3_side_in.rel[i] = S32_MIN[P_W-1:0];
         else                  s3_side_in.rel[i] = t[P_W-1:0];
      end
      s3_side_in.lock = (m[0] == '0) && (m[1] == '0);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         logic signed [2*M_W-1:0] p00, p10;
         p00 = s3_side_ff.m00 * s3_side_ff.m00;
         p10 = s3_side_ff.m10 * s3_side_ff.m10;
         s3_side_ff <= s3_side_in;
         s4_side_ff <= s3_side_ff;
         s4_sq00_ff <= p00[SQ_W-1:0];
         s4_sq10_ff <= p10[SQ_W-1:0];
         s5_side_ff <= s4_side_ff;
         s5_sum_ff  <= s4_sq00_ff + s4_sq10_ff;
         sd1_ff[0]  <= s5_side_ff;
         for (int i = 1; i < SQRT_STEPS; i++) sd1_ff[i] <= sd1_ff[i-1];
         sd2_ff[0].rel  <= sd1_ff[SQRT_STEPS-1].rel;
         sd2_ff[0].lock <= sd1_ff[SQRT_STEPS-1].lock;
         for (int i = 1; i < CORDIC_DEPTH; i++) sd2_ff[i] <= sd2_ff[i-1];
      end
   end

   rpe_isqrt u_isqrt (
      .clock    (clock),
      .pipe_en  (pipe_en),
      .val_in   (s5_sum_ff),
      .root_out (hyp)
   );

   assign cs = sd1_ff[SQRT_STEPS-1];

   rpe_cordic u_pitch (
      .clock    (clock),
      .pipe_en  (pipe_en),
      .y_in     (-CIN_W'(cs.m20)),
      .x_in     (CIN_W'({1'b0, hyp})),
      .ang_out  (ang_p),
      .zero_out (zero_p)
   );

   rpe_cordic u_yaw (
      .clock    (clock),
      .pipe_en  (pipe_en),
      .y_in     (CIN_W'(cs.m10)),
      .x_in     (CIN_W'(cs.m00)),
      .ang_out  (ang_y),
      .zero_out (zero_y)
   );

   rpe_cordic u_roll (
      .clock    (clock),
      .pipe_en  (pipe_en),
      .y_in     (CIN_W'(cs.m21)),
      .x_in     (CIN_W'(cs.m22)),
      .ang_out  (ang_r),
      .zero_out (zero_r)
   );

   // round Q20 degrees to 1/128 degree and clamp to the limit; a zero vector gives zero
   function automatic logic signed [DEG_W-1:0] to_deg(
      input logic signed [ANG_W-1:0] a,
      input logic                    z,
      input logic signed [DEG_W-1:0] lim
   );
      logic signed [ANG_W-1:0] rr;
      logic signed [DEG_W-1:0] d;
      rr = (a + HALF13) >>> 13;
      d  = rr[DEG_W-1:0];
      if (z)             return '0;
      else if (d > lim)  return lim;
      else if (d < -lim) return -lim;
      else               return d;
   endfunction

   assign pitch_in = to_deg(ang_p, zero_p, PITCH_LIM);
   assign yaw_in   = to_deg(ang_y, zero_y, ROLL_LIM);
   assign roll_in  = to_deg(ang_r, zero_r, ROLL_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= v_ff[NV-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pitch_ff <= pitch_in[14:0];
         // drop roll and yaw at gimbal lock
         roll_ff  <= sd2_ff[CORDIC_DEPTH-1].lock ? '0 : roll_in[15:0];
         yaw_ff   <= sd2_ff[CORDIC_DEPTH-1].lock ? '0 : yaw_in[15:0];
         rel_ff   <= sd2_ff[CORDIC_DEPTH-1].rel;
         lock_ff  <= sd2_ff[CORDIC_DEPTH-1].lock;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_deg    = roll_ff;
   assign rsp_pitch_deg   = pitch_ff;
   assign rsp_yaw_deg     = yaw_ff;
   assign rsp_rel_x       = rel_ff[0];
   assign rsp_rel_y       = rel_ff[1];
   assign rsp_rel_z       = rel_ff[2];
   assign rsp_gimbal_lock = lock_ff;

endmodule

// ===== src/rpe_checker.sv =====
// Port-level checks of the relative pose core and their binding.
module rpe_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic signed [rpe_pkg::P_W-1:0] req_pos_x,
   input logic signed [rpe_pkg::P_W-1:0] req_pos_y,
   input logic signed [rpe_pkg::P_W-1:0] req_pos_z,
   input logic signed [rpe_pkg::Q_W-1:0] req_quat_x,
   input logic signed [rpe_pkg::Q_W-1:0] req_quat_y,
   input logic signed [rpe_pkg::Q_W-1:0] req_quat_z,
   input logic signed [rpe_pkg::Q_W-1:0] req_quat_w,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [15:0]             rsp_roll_deg,
   input logic signed [14:0]             rsp_pitch_deg,
   input logic signed [15:0]             rsp_yaw_deg,
   input logic signed [rpe_pkg::P_W-1:0] rsp_rel_x,
   input logic signed [rpe_pkg::P_W-1:0] rsp_rel_y,
   input logic signed [rpe_pkg::P_W-1:0] rsp_rel_z,
   input logic                           rsp_gimbal_lock,
   input logic                           csr_we,
   input logic [rpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [31:0]                    csr_wdata
);
   import rpe_pkg::*;

   // a held result item stays valid with rel_x, pitch, roll and lock unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rel_x) && $stable(rsp_pitch_deg)
         && $stable(rsp_roll_deg) && $stable(rsp_gimbal_lock))
      else $error("result item changed while stalled");

   // the input side stalls exactly when the output is blocked
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output blocking");

   // gimbal lock forces roll and yaw to zero
   a_lock: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gimbal_lock |-> rsp_roll_deg == 16'sd0 && rsp_yaw_deg == 16'sd0)
      else $error("roll or yaw nonzero at gimbal lock");

   // pitch stays within a quarter turn
   a_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_deg <= 15'sd11520 && rsp_pitch_deg >= -15'sd11520)
      else $error("pitch out of range");

endmodule

bind relative_pose_euler_core rpe_checker u_rpe_checker (.*);

// ===== tb/pose_scoreboard.sv =====
// Scoreboard for the relative pose core: own predictor, queue of pending results.
`timescale 1ns / 1ps

typedef struct packed {
   logic signed [15:0] roll;
   logic signed [14:0] pitch;
   logic signed [15:0] yaw;
   logic signed [31:0] rel_x;
   logic signed [31:0] rel_y;
   logic signed [31:0] rel_z;
   logic               lock;
} pose_result_type;

class pose_scoreboard;
   longint          ref_t[3];
   longint          ref_q[4];
   pose_result_type pending_results[$];
   int              errors;

   function new();
      clear_ref();
      errors = 0;
   endfunction

   function void clear_ref();
      ref_t = '{0, 0, 0};
      ref_q = '{0, 0, 0, 16384};
   endfunction

   function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         rpe_pkg::CSR_REF_X:  ref_t[0] = longint'($signed(val));
         rpe_pkg::CSR_REF_Y:  ref_t[1] = longint'($signed(val));
         rpe_pkg::CSR_REF_Z:  ref_t[2] = longint'($signed(val));
         rpe_pkg::CSR_REF_QX: ref_q[0] = longint'($signed(val[15:0]));
         rpe_pkg::CSR_REF_QY: ref_q[1] = longint'($signed(val[15:0]));
         rpe_pkg::CSR_REF_QZ: ref_q[2] = longint'($signed(val[15:0]));
         rpe_pkg::CSR_REF_QW: ref_q[3] = longint'($signed(val[15:0]));
         default: ;
      endcase
   endfunction

   static function logic signed [127:0] round_shift(logic signed [127:0] v, int s);
      logic signed [127:0] one;
      one = 1;
      return (v + (one <<< (s - 1))) >>> s;
   endfunction

   static function void quat_rot(longint x, longint y, longint z, longint w,
                                 output longint r[3][3]);
      longint xx, yy, zz, xy, xz, yz, xw, yw, zw, one;
      xx = x * x; yy = y * y; zz = z * z;
      xy = x * y; xz = x * z; yz = y * z;
      xw = x * w; yw = y * w; zw = z * w;
      one = 64'sd1 <<< 28;
      r[0][0] = 64'(round_shift(one - 2 * (yy + zz), 4));
      r[0][1] = 64'(round_shift(2 * (xy - zw), 4));
      r[0][2] = 64'(round_shift(2 * (xz + yw), 4));
      r[1][0] = 64'(round_shift(2 * (xy + zw), 4));
      r[1][1] = 64'(round_shift(one - 2 * (xx + zz), 4));
      r[1][2] = 64'(round_shift(2 * (yz - xw), 4));
      r[2][0] = 64'(round_shift(2 * (xz - yw), 4));
      r[2][1] = 64'(round_shift(2 * (yz + xw), 4));
      r[2][2] = 64'(round_shift(one - 2 * (xx + yy), 4));
   endfunction

   static function longint unsigned int_sqrt(longint unsigned s);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // vectoring arctangent, result in 1/128 degree before clamping
   static function longint arctan_deg(longint y, longint x);
      longint ang, t, xs, ys;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; ang = 90 * 1048576;
         end else begin
            x = -y; y = t; ang = -90 * 1048576;
         end
      end
      for (int i = 0; i < rpe_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; ang += longint'(rpe_pkg::atan_q20(i));
         end else begin
            x -= ys; y += xs; ang -= longint'(rpe_pkg::atan_q20(i));
         end
      end
      return 64'(round_shift(ang, 13));
   endfunction

   static function longint clamp(longint v, longint lim_lo, longint lim_hi);
      return v < lim_lo ? lim_lo : (v > lim_hi ? lim_hi : v);
   endfunction

   // predict the result for one accepted pose and queue it
   function void note_pose(logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz, logic signed [15:0] qx,
                           logic signed [15:0] qy, logic signed [15:0] qz,
                           logic signed [15:0] qw);
      longint r1[3][3], r2[3][3], m[3][3], d[3];
      logic signed [127:0] acc;
      longint rel;
      longint unsigned hyp;
      pose_result_type res;
      d[0] = longint'(px) - ref_t[0];
      d[1] = longint'(py) - ref_t[1];
      d[2] = longint'(pz) - ref_t[2];
      quat_rot(ref_q[0], ref_q[1], ref_q[2], ref_q[3], r1);
      quat_rot(qx, qy, qz, qw, r2);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
               acc += 128'(r1[k][i]) * 128'(r2[k][j]);
            m[i][j] = 64'(round_shift(acc, 28));
         end
         acc = 0;
         for (int k = 0; k < 3; k++)
            acc += 128'(r1[k][i]) * 128'(d[k]);
         acc = round_shift(acc, 24);
         if (acc > 128'sd2147483647) rel = 2147483647;
         else if (acc < -128'sd2147483648) rel = -2147483648;
         else rel = 64'(acc);
         case (i)
            0: res.rel_x = 32'(rel);
            1: res.rel_y = 32'(rel);
            default: res.rel_z = 32'(rel);
         endcase
      end
      hyp = int_sqrt(longint'(unsigned'(m[0][0] * m[0][0])) +
                     longint'(unsigned'(m[1][0] * m[1][0])));
      res.pitch = 15'(clamp(arctan_deg(-m[2][0], longint'(hyp)), -11520, 11520));
      res.lock  = (m[0][0] == 0 && m[1][0] == 0);
      res.roll  = '0;
      res.yaw   = '0;
      if (!res.lock) begin
         res.yaw  = 16'(clamp(arctan_deg(m[1][0], m[0][0]), -23040, 23040));
         res.roll = 16'(clamp(arctan_deg(m[2][1], m[2][2]), -23040, 23040));
      end
      pending_results.push_back(res);
   endfunction

   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_result(pose_result_type got);
      pose_result_type exp;
      if (pending_results.size() == 0) begin
         report("result item with nothing pending");
         return;
      end
      exp = pending_results.pop_front();
      if (got.roll !== exp.roll)
         report($sformatf("roll %0d, wanted %0d", got.roll, exp.roll));
      if (got.pitch !== exp.pitch)
         report($sformatf("pitch %0d, wanted %0d", got.pitch, exp.pitch));
      if (got.yaw !== exp.yaw)
         report($sformatf("yaw %0d, wanted %0d", got.yaw, exp.yaw));
      if (got.rel_x !== exp.rel_x)
         report($sformatf("rel_x %0d, wanted %0d", got.rel_x, exp.rel_x));
      if (got.rel_y !== exp.rel_y)
         report($sformatf("rel_y %0d, wanted %0d", got.rel_y, exp.rel_y));
      if (got.rel_z !== exp.rel_z)
         report($sformatf("rel_z %0d, wanted %0d", got.rel_z, exp.rel_z));
      if (got.lock !== exp.lock)
         report($sformatf("gimbal_lock %0b, wanted %0b", got.lock, exp.lock));
   endtask
endclass

// ===== tb/relative_pose_euler_core_test.sv =====
// Top level of the relative pose core testbench: clock, drivers, monitor and phases.
`timescale 1ns / 1ps

module relative_pose_euler_core_test;
   import rpe_pkg::*;

   localparam int LATENCY     = 65;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS_PER_PHASE = 110;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [15:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic signed [15:0] req_quat_w = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_roll_deg, rsp_yaw_deg;
   logic signed [14:0] rsp_pitch_deg;
   logic signed [31:0] rsp_rel_x, rsp_rel_y, rsp_rel_z;
   logic               rsp_gimbal_lock;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   pose_scoreboard pose_board = new();

   int  send_idle_pct  = 0;   // chance per cycle that the sender stays idle
   int  recv_stall_pct = 0;   // chance per cycle that the receiver stalls
   int  holdoff_left   = 0;   // long receiver hold-off, counted in cycles
   int  cycle_count    = 0;
   bit  req_took       = 1'b0;

   // values sampled just ahead of each rising edge
   logic        s_req_valid, s_req_stall, s_rsp_valid, s_rsp_stall;
   logic [31:0] s_px, s_py, s_pz;
   logic [15:0] s_qx, s_qy, s_qz, s_qw;
   pose_result_type s_res;

   relative_pose_euler_core uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // cycle counter: stop the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // monitor: sample mid low phase, act on the rising edge that follows
   always begin
      @(negedge clock);
      #0.5;
      s_req_valid = req_valid;
      s_req_stall = req_stall;
      s_rsp_valid = rsp_valid;
      s_rsp_stall = rsp_stall;
      s_px = req_pos_x; s_py = req_pos_y; s_pz = req_pos_z;
      s_qx = req_quat_x; s_qy = req_quat_y; s_qz = req_quat_z; s_qw = req_quat_w;
      s_res = '{rsp_roll_deg, rsp_pitch_deg, rsp_yaw_deg, rsp_rel_x, rsp_rel_y,
                rsp_rel_z, rsp_gimbal_lock};
      @(posedge clock);
      req_took = !reset && s_req_valid && !s_req_stall;
      if (req_took)
         pose_board.note_pose(s_px, s_py, s_pz, s_qx, s_qy, s_qz, s_qw);
      if (!reset && s_rsp_valid && !s_rsp_stall)
         pose_board.check_result(s_res);
   end

   // receiver: random stall, or hold off entirely while a hold-off runs
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_stall = 1'b1;
         holdoff_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
      end
   end

   // offer one pose item and hold it until it is taken
   task send_pose(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                  logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                  logic [15:0] qw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_pos_x = px; req_pos_y = py; req_pos_z = pz;
      req_quat_x = qx; req_quat_y = qy; req_quat_z = qz; req_quat_w = qw;
      req_valid = 1'b1;
      do @(negedge clock); while (!req_took);
   endtask

   // write one reference register; only called with the pipeline empty
   task write_ref(logic [2:0] idx, logic [31:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
      pose_board.set_reg(idx, val);
   endtask

   task write_ref_pose(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                       logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                       logic [15:0] qw);
      write_ref(CSR_REF_X, x);
      write_ref(CSR_REF_Y, y);
      write_ref(CSR_REF_Z, z);
      // pad the upper bits: only the low half counts for quaternion registers
      write_ref(CSR_REF_QX, {16'($urandom_range(65535)), qx});
      write_ref(CSR_REF_QY, {16'($urandom_range(65535)), qy});
      write_ref(CSR_REF_QZ, {16'($urandom_range(65535)), qz});
      write_ref(CSR_REF_QW, {16'($urandom_range(65535)), qw});
   endtask

   // drop valid and wait until every pending result has come back
   task drain;
      req_valid = 1'b0;
      while (pose_board.pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_quat_part();
      return 16'($urandom_range(65535));
   endfunction

   // random pose: mostly near-unit quaternions and modest translations
   task send_random_pose;
      real a, b, c, e, n;
      logic [31:0] t[3];
      logic [15:0] q[4];
      for (int i = 0; i < 3; i++)
         t[i] = ($urandom_range(3) == 0) ? $urandom :
                32'($signed(24'($urandom)));
      if ($urandom_range(4) == 0) begin
         for (int i = 0; i < 4; i++) q[i] = rand_quat_part();
      end else begin
         a = $itor($signed(16'($urandom)));
         b = $itor($signed(16'($urandom)));
         c = $itor($signed(16'($urandom)));
         e = $itor($signed(16'($urandom)));
         n = $sqrt(a * a + b * b + c * c + e * e) + 1.0;
         q[0] = 16'($rtoi(a / n * 16384.0));
         q[1] = 16'($rtoi(b / n * 16384.0));
         q[2] = 16'($rtoi(c / n * 16384.0));
         q[3] = 16'($rtoi(e / n * 16384.0));
      end
      send_pose(t[0], t[1], t[2], q[0], q[1], q[2], q[3]);
   endtask

   task run_random(int count);
      repeat (count) send_random_pose();
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: identity reference from reset
      send_pose(0, 0, 0, 0, 0, 0, 16384);
      send_pose(32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0, 0, 16384);
      send_pose(32'h80000000, 32'h7fffffff, 32'hffffffff, 16384, 0, 0, 0);
      send_pose(0, 0, 0, 0, 0, 0, 0);                      // zero quaternion
      send_pose(0, 0, 0, 0, 8192, 8192, 0);                // gimbal lock
      send_pose(0, 0, 0, 0, 16'hE000, 8192, 0);            // gimbal lock, mirrored
      send_pose(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_pose(0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_pose(0, 0, 0, 16'hC000, 0, 0, 0);
      send_pose(0, 0, 0, 0, 16384, 0, 0);
      send_pose(0, 0, 0, 0, 0, 16384, 0);
      send_pose(0, 0, 0, 11585, 0, 0, 11585);
      send_pose(0, 0, 0, 0, 11585, 0, 11585);
      send_pose(0, 0, 0, 0, 0, 16'hD2BF, 11585);
      send_pose(0, 0, 0, 0, 0, 0, 16'hC000);
      drain();

      // directed: extreme reference, translation saturates
      write_ref_pose(32'h80000000, 32'h7fffffff, 32'h80000000,
                     16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      write_ref(3'd7, $urandom);                           // unknown index, ignored
      send_pose(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 16384);
      send_pose(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_pose(0, 0, 0, 0, 8192, 8192, 0);
      send_pose(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
      drain();

      // phase with no idling; hold the receiver off so the pipeline backs up
      write_ref_pose($urandom, $urandom, $urandom, 0, 0, 0, 16384);
      send_idle_pct = 0; recv_stall_pct = 0;
      holdoff_left = 300;
      run_random(RANDOM_ITEMS_PER_PHASE);
      drain();

      // sender mostly idle, random reference
      write_ref_pose($urandom, $urandom, $urandom,
                     rand_quat_part(), rand_quat_part(), rand_quat_part(),
                     rand_quat_part());
      send_idle_pct = 77; recv_stall_pct = 0;
      run_random(RANDOM_ITEMS_PER_PHASE);
      drain();

      // receiver mostly stalling, near-unit reference
      write_ref_pose(32'($signed(20'($urandom))), 32'($signed(20'($urandom))),
                     32'($signed(20'($urandom))), 6270, 16'hE782, 2000, 14000);
      send_idle_pct = 0; recv_stall_pct = 77;
      run_random(RANDOM_ITEMS_PER_PHASE);
      drain();

      // both sides idling, reference back to the reset pose
      write_ref_pose(0, 0, 0, 0, 0, 0, 16384);
      send_idle_pct = 31; recv_stall_pct = 31;
      run_random(RANDOM_ITEMS_PER_PHASE);
      drain();

      if (pose_board.errors == 0 && pose_board.pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
